// ===== hw/rtl/lzss_fb_pkg.sv =====
// ----------------------------------------------------------------------------
// lzss_fb_pkg
// Shared types and constants for the flag-byte LZSS decompressor.
// ----------------------------------------------------------------------------
package lzss_fb_pkg;

  localparam int HISTORY_DEPTH_DEF = 4096;
  localparam int COUNT_W           = 24;  // output length / remaining count
  localparam int DIST_W            = 13;  // match distance, 1..4096
  localparam int LEN_W             = 5;   // match length, 1..18
  localparam int MODE_W            = 2;
  localparam int CFG_IDX_W         = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MATCH_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH  = 1'd1;

  localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;

  // parser phases
  localparam logic [1:0] PH_FLAG = 2'd0;  // expect flag byte
  localparam logic [1:0] PH_DATA = 2'd1;  // expect literal or token low byte
  localparam logic [1:0] PH_HIGH = 2'd2;  // expect token high byte

  // what an incoming word does
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_LIT   = 2'd1;
  localparam logic [1:0] KIND_MATCH = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_entry;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_entry;
  } out_word_t;

  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic rd;      // read history for next copy byte
    logic copy;    // write back and emit the copy byte
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;       // effect of the presented input word
    logic       copy_last;  // current copy byte ends the match
    logic       out_free;   // output register can take a word
  } dp_status_t;

endpackage

// ===== hw/rtl/lzss_fb_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzss_fb_ctrl
// Sequencer: takes input words and steps a match copy one byte at a time.
// ----------------------------------------------------------------------------
module lzss_fb_ctrl import lzss_fb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IN = 2'd0;
  localparam logic [1:0] S_RD = 2'd1;
  localparam logic [1:0] S_WR = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IN) && status.out_free;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.rd     = 1'b0;
    cmd.copy   = 1'b0;
    unique case (state_r)
      S_IN: begin
        cmd.accept = in_valid && in_ready;
        if (cmd.accept && (status.kind == KIND_MATCH)) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (status.out_free) begin
          cmd.copy  = 1'b1;
          state_nxt = status.copy_last ? S_IN : S_RD;
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/lzss_fb_datapath.sv =====
// ----------------------------------------------------------------------------
// lzss_fb_datapath
// Parser registers, history memory, match counters and output register.
// ----------------------------------------------------------------------------
module lzss_fb_datapath import lzss_fb_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data,
  input  in_word_t             in_word,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_word_t            out_word
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic [7:0] hist_mem [HISTORY_DEPTH];

  logic [1:0]         phase_r, phase_nxt;
  logic [2:0]         fidx_r, fidx_nxt;
  logic [7:0]         fbits_r, fbits_nxt;
  logic [7:0]         low_r, low_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic               done_r, done_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [MODE_W-1:0]  mode_r;
  logic [COUNT_W-1:0] olen_r;
  logic [LEN_W-1:0]   copy_left_r, copy_left_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [7:0]         rd_data_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  // effective parser state, after an entry start on the presented word
  logic               start;
  logic [1:0]         phase_e;
  logic [2:0]         fidx_e;
  logic [7:0]         fbits_e;
  logic [COUNT_W-1:0] rem_e;
  logic               done_e;
  logic [1:0]         kind;

  logic [MODE_W-1:0]  mode_sat;
  logic [LEN_W-1:0]   len_raw, len_clamp;
  logic [AW:0]        src_wide;
  logic [AW-1:0]      rd_addr;

  logic               emit_lit, emit;
  logic [7:0]         emit_byte;
  logic [COUNT_W-1:0] rem_base, rem_after;
  logic [AW-1:0]      wp_inc;

  assign start   = in_word.start_of_entry;
  assign phase_e = start ? PH_FLAG : phase_r;
  assign fidx_e  = start ? 3'd0 : fidx_r;
  assign fbits_e = start ? 8'd0 : fbits_r;
  assign rem_e   = start ? olen_r : rem_r;
  assign done_e  = start ? (olen_r == '0) : done_r;

  always_comb begin
    kind = KIND_NONE;
    if (!done_e) begin
      if ((phase_e == PH_DATA) && fbits_e[fidx_e]) begin
        kind = KIND_LIT;
      end else if (phase_e == PH_HIGH) begin
        kind = KIND_MATCH;
      end
    end
  end

  // match length: nibble + mode + 1, cut at the remaining count
  assign mode_sat  = (mode_r > MODE_MAX) ? MODE_MAX : mode_r;
  assign len_raw   = LEN_W'(low_r[3:0]) + LEN_W'(mode_sat) + LEN_W'(1);
  assign len_clamp = (COUNT_W'(len_raw) > rem_e) ? rem_e[LEN_W-1:0] : len_raw;

  // copy source: write position minus distance, modulo the window
  always_comb begin
    if ({1'b0, wp_r} >= (AW+1)'(dist_r)) begin
      src_wide = {1'b0, wp_r} - (AW+1)'(dist_r);
    end else begin
      src_wide = {1'b0, wp_r} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(dist_r);
    end
  end
  assign rd_addr = src_wide[AW-1:0];

  assign emit_lit  = cmd.accept && (kind == KIND_LIT);
  assign emit      = emit_lit || cmd.copy;
  assign emit_byte = emit_lit ? in_word.in_byte : rd_data_r;
  assign rem_base  = emit_lit ? rem_e : rem_r;
  assign rem_after = (rem_base == '0) ? '0 : rem_base - COUNT_W'(1);
  assign wp_inc    = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);

  always_comb begin
    phase_nxt     = phase_r;
    fidx_nxt      = fidx_r;
    fbits_nxt     = fbits_r;
    low_nxt       = low_r;
    rem_nxt       = rem_r;
    done_nxt      = done_r;
    wp_nxt        = wp_r;
    copy_left_nxt = copy_left_r;
    dist_nxt      = dist_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.accept) begin
      phase_nxt = phase_e;
      fidx_nxt  = fidx_e;
      fbits_nxt = fbits_e;
      rem_nxt   = rem_e;
      done_nxt  = done_e;
      if (start) begin
        low_nxt = 8'd0;
      end
      if (!done_e) begin
        unique case (phase_e)
          PH_DATA: begin
            if (fbits_e[fidx_e]) begin
              fidx_nxt  = fidx_e + 3'd1;
              phase_nxt = (fidx_e == 3'd7) ? PH_FLAG : PH_DATA;
            end else begin
              low_nxt   = in_word.in_byte;
              phase_nxt = PH_HIGH;
            end
          end
          PH_HIGH: begin
            copy_left_nxt = len_clamp;
            dist_nxt      = DIST_W'({in_word.in_byte, low_r[7:4]}) + DIST_W'(1);
            fidx_nxt      = fidx_e + 3'd1;
            phase_nxt     = (fidx_e == 3'd7) ? PH_FLAG : PH_DATA;
          end
          default: begin
            fbits_nxt = in_word.in_byte;
            fidx_nxt  = 3'd0;
            phase_nxt = PH_DATA;
          end
        endcase
      end
    end

    if (cmd.copy) begin
      copy_left_nxt = copy_left_r - LEN_W'(1);
    end

    if (emit) begin
      wp_nxt  = wp_inc;
      rem_nxt = rem_after;
      if (rem_after == '0) begin
        done_nxt = 1'b1;
      end
      out_valid_nxt             = 1'b1;
      out_word_nxt.out_byte     = emit_byte;
      out_word_nxt.last_of_run  = emit_lit || (copy_left_r == LEN_W'(1));
      out_word_nxt.end_of_entry = (rem_after == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FLAG;
      fidx_r      <= '0;
      fbits_r     <= '0;
      low_r       <= '0;
      rem_r       <= '0;
      done_r      <= 1'b1;
      wp_r        <= '0;
      mode_r      <= MODE_W'(1);
      olen_r      <= COUNT_W'(1);
      copy_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      fidx_r      <= fidx_nxt;
      fbits_r     <= fbits_nxt;
      low_r       <= low_nxt;
      rem_r       <= rem_nxt;
      done_r      <= done_nxt;
      wp_r        <= wp_nxt;
      copy_left_r <= copy_left_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_MATCH_MODE: mode_r <= cfg_data[MODE_W-1:0];
          CFG_OUTPUT_LENGTH:  olen_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    out_word_r <= out_word_nxt;
  end

  // history window: one write, one registered read
  always_ff @(posedge clk) begin
    if (emit) begin
      hist_mem[wp_r] <= emit_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  assign status.kind      = kind;
  assign status.copy_last = (copy_left_r == LEN_W'(1));
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== hw/rtl/lzss_flag_byte_decompressor.sv =====
// ----------------------------------------------------------------------------
// lzss_flag_byte_decompressor
// Flag-byte LZSS decoder, 12-bit distance and 4-bit length tokens.
// ----------------------------------------------------------------------------
// The compressed stream comes in one byte per input word; decoded bytes leave
// one per output word. A flag byte (LSB first) tells whether each of the next
// eight tokens is a literal byte or a two-byte little-endian match token
// (length = low nibble + min_match_mode + 1, distance = upper 12 bits + 1).
// Each flag byte, token low byte or literal is taken as one input word. A
// match token is accepted, then each copied byte takes a history read,
// registered, then write-back and emit; the registered read of the history
// memory sets this order. The output register decouples the sink; while it
// is full, a stall on out_ready holds off both input words and copy bytes.
// start_of_entry on a word reloads the byte count from output_length; a
// match running past that count is cut short, and end_of_entry marks the
// final byte. Words arriving after the entry is done are swallowed until
// the next start_of_entry. The history window keeps its contents across
// entries and has no clearing pass: copies must not reach bytes that were
// never written. Configuration writes (cfg_index 0: mode, 1: output length)
// must only be made while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module lzss_flag_byte_decompressor import lzss_fb_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data,
  // compressed words in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  // decoded words out
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: input accept and match copy stepping
  lzss_fb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // parser state, history window and output register
  lzss_fb_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // a copy byte is only emitted when the output register can take it
  a_copy_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy |-> status.out_free)
    else $error("copy byte emitted into a full output register");

  // no input word is taken while a match is being copied
  a_no_accept_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> !in_ready)
    else $error("input accepted during a match copy");

  // every history read is followed by its write-back slot, never another read
  a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> !cmd.rd && !cmd.accept)
    else $error("history read not followed by write-back");

  // a match accept always starts a copy on the next cycle
  a_match_starts_copy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && (status.kind == KIND_MATCH) |=> cmd.rd)
    else $error("match token accepted without starting a copy");

endmodule
